@@ rtl/core/phm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phm_pkg: shared definitions of the peak hold bar meter
// Field widths, register indexes and reset values used by the channel
// interfaces and the meter core.
// ----------------------------------------------------------------------------
package phm_pkg;

  localparam int unsigned LevelW   = 6;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned MaskW    = 43;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned MaxLevelDefault = 42;

  localparam logic [HoldW-1:0]  HoldMsReset     = HoldW'(200);
  localparam logic [LevelW-1:0] GreenLimitReset = LevelW'(18);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HOLD_MS     = 1'b0,
    CFG_GREEN_LIMIT = 1'b1
  } cfg_idx_e;

endpackage

@@ rtl/core/phm_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phm_ifs: valid/ready channels of the peak hold bar meter
// One channel carries level samples in, the other carries meter words out.
// ----------------------------------------------------------------------------
interface phm_in_if;
  logic                            valid;
  logic                            ready;
  logic [phm_pkg::LevelW-1:0]      level;
  logic [phm_pkg::TimeW-1:0]       now_ms;

  modport source (output valid, output level, output now_ms, input ready);
  modport sink   (input valid, input level, input now_ms, output ready);
endinterface

interface phm_out_if;
  logic                            valid;
  logic                            ready;
  logic [phm_pkg::LevelW-1:0]      shown_level;
  logic [phm_pkg::LevelW-1:0]      peak_level;
  logic [phm_pkg::MaskW-1:0]       lit_mask;
  logic [phm_pkg::MaskW-1:0]       red_mask;
  logic [phm_pkg::MaskW-1:0]       peak_mask;

  modport source (output valid, output shown_level, output peak_level,
                  output lit_mask, output red_mask, output peak_mask, input ready);
  modport sink   (input valid, input shown_level, input peak_level,
                  input lit_mask, input red_mask, input peak_mask, output ready);
endinterface

@@ rtl/core/peak_hold_bar_meter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_hold_bar_meter: bar graph meter with peak hold and decay
// Tracks a bar level, a peak marker and the peak time from a stream of level
// samples and emits the bar, the peak and the segment masks for each sample.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake        | word
//  ---------+-----+------------------+-------------------------------------------
//  in_if    | in  | valid/ready      | level, now_ms
//  out_if   | out | valid/ready      | shown_level, peak_level, lit/red/peak mask
//  cfg      | in  | cfg_we_i only    | cfg_idx_i, cfg_data_i (hold_ms, green_limit)
//
//  One word per cycle sustained while the output takes every word; an accepted
//  word passes the input register and then the result register. Stage 1 is
//  the input register, stage 2 updates meter state and loads the result
//  register; the state loop closes within stage 2. A stalled result holds both
//  stages; the input register still takes one more word while the result waits.
//  Reset clears state, registers to their defaults and all valid flags.
//
module peak_hold_bar_meter #(
  parameter int unsigned MAX_LEVEL = phm_pkg::MaxLevelDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [phm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [phm_pkg::CfgDataW-1:0]   cfg_data_i,
  phm_in_if.sink                         in_if,
  phm_out_if.source                      out_if
);

  localparam int unsigned LW = phm_pkg::LevelW;
  localparam int unsigned TW = phm_pkg::TimeW;
  localparam int unsigned HW = phm_pkg::HoldW;
  localparam int unsigned MW = phm_pkg::MaskW;
  localparam logic [LW-1:0] MaxLvl = LW'(MAX_LEVEL);

  // Configuration registers
  logic [HW-1:0] hold_ms_q;
  logic [LW-1:0] green_limit_q;

  // Stage 1: input register
  logic          s1_valid_q;
  logic [LW-1:0] s1_level_q;
  logic [TW-1:0] s1_now_q;

  // Meter state
  logic [LW-1:0] bar_q, bar_d;
  logic [LW-1:0] peak_q, peak_d;
  logic [TW-1:0] peak_time_q, peak_time_d;

  // Stage 2: result register
  logic          out_valid_q;
  logic [LW-1:0] out_shown_q, out_peak_q;
  logic [MW-1:0] out_lit_q, out_red_q, out_pk_q;
  logic [MW-1:0] lit_d, red_d, pk_d;

  logic          advance;
  logic          in_ready;
  logic          fire;
  logic [TW-1:0] elapsed;
  logic          hold_passed;

  // Advance the pipeline whenever the result slot is free or being taken.
  assign advance  = !out_valid_q || out_if.ready;
  assign in_ready = !s1_valid_q || advance;
  assign fire     = s1_valid_q && advance;

  assign in_if.ready = in_ready;

  // Write configuration; indexes outside the list do not occur in this width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ms_q     <= phm_pkg::HoldMsReset;
      green_limit_q <= phm_pkg::GreenLimitReset;
    end else if (cfg_we_i) begin
      unique case (phm_pkg::cfg_idx_e'(cfg_idx_i))
        phm_pkg::CFG_HOLD_MS:     hold_ms_q     <= cfg_data_i[HW-1:0];
        phm_pkg::CFG_GREEN_LIMIT: green_limit_q <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: capture a word whenever the input register is free to take one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_if.valid) begin
      s1_level_q <= in_if.level;
      s1_now_q   <= in_if.now_ms;
    end
  end

  // Hold has passed when the wrapped difference is non-negative and above hold_ms.
  assign elapsed     = s1_now_q - peak_time_q;
  assign hold_passed = !elapsed[TW-1] &&
                       (elapsed[TW-2:0] > {{(TW-1-HW){1'b0}}, hold_ms_q});

  // Stage 2: meter update.
  always_comb begin
    bar_d       = bar_q;
    peak_d      = peak_q;
    peak_time_d = peak_time_q;
    if (s1_level_q > bar_q) begin
      // Rise: jump bar and peak, stamp the peak time; clamp only the bar.
      bar_d       = (s1_level_q > MaxLvl) ? MaxLvl : s1_level_q;
      peak_d      = s1_level_q;
      peak_time_d = s1_now_q;
    end else if (s1_level_q < bar_q) begin
      // Fall: drop the bar one step, drop the peak one step after the hold.
      bar_d = bar_q - LW'(1);
      if (hold_passed) begin
        if (peak_q != '0) begin
          peak_d = peak_q - LW'(1);
        end
        peak_time_d = s1_now_q;
      end
    end else if ((peak_q > bar_q) && hold_passed) begin
      // Unchanged: decay a floating peak by two, restamp only if it was above one.
      if (peak_q > LW'(1)) begin
        peak_d      = peak_q - LW'(2);
        peak_time_d = s1_now_q;
      end else begin
        peak_d = '0;
      end
    end
  end

  // Segment masks from the updated state.
  always_comb begin
    for (int unsigned i = 0; i < MW; i++) begin
      lit_d[i] = LW'(i) < bar_d;
      red_d[i] = lit_d[i] && (LW'(i) > green_limit_q);
      pk_d[i]  = (peak_d == LW'(i)) && (peak_d <= MaxLvl);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_q       <= '0;
      peak_q      <= '0;
      peak_time_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        bar_q       <= bar_d;
        peak_q      <= peak_d;
        peak_time_q <= peak_time_d;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_shown_q <= bar_d;
      out_peak_q  <= peak_d;
      out_lit_q   <= lit_d;
      out_red_q   <= red_d;
      out_pk_q    <= pk_d;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.shown_level = out_shown_q;
  assign out_if.peak_level  = out_peak_q;
  assign out_if.lit_mask    = out_lit_q;
  assign out_if.red_mask    = out_red_q;
  assign out_if.peak_mask   = out_pk_q;

`ifndef SYNTHESIS
  // The bar never climbs past full scale.
  a_bar_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bar_q <= MaxLvl)
    else $error("bar level above full scale");

  // At most one peak segment is lit in any result.
  a_peak_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0(out_pk_q))
    else $error("peak mask not one-hot");

  // Red segments are always a subset of lit segments.
  a_red_in_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_red_q & ~out_lit_q) == '0))
    else $error("red segment outside the bar");

  // The lit mask agrees with the reported bar length.
  a_lit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($countones(out_lit_q) == int'(out_shown_q)))
    else $error("lit mask does not match shown level");

  // State moves only when a word passes through stage 2.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> ($stable(bar_q) && $stable(peak_q) && $stable(peak_time_q)))
    else $error("meter state changed without a word");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the peak hold bar meter
// Streams level samples with timestamps into the meter and checks every meter
// word it returns. A local model of the bar, the peak marker and the peak
// time predicts each word. Both channels stall at random, and the run covers
// several hold times and green limits, the extremes among them.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MaxLevel = phm_pkg::MaxLevelDefault;

  // One level sample as it travels on the input channel.
  typedef struct packed {
    logic [phm_pkg::LevelW-1:0] level;
    logic [phm_pkg::TimeW-1:0]  now_ms;
  } sample_t;

  // Meter state: bar length, peak marker and the time the peak was last set.
  typedef struct packed {
    logic [phm_pkg::LevelW-1:0] bar;
    logic [phm_pkg::LevelW-1:0] peak;
    logic [phm_pkg::TimeW-1:0]  ptime;
  } meter_state_t;

  // One meter word as it leaves on the output channel.
  typedef struct packed {
    logic [phm_pkg::LevelW-1:0] shown;
    logic [phm_pkg::LevelW-1:0] peak;
    logic [phm_pkg::MaskW-1:0]  lit;
    logic [phm_pkg::MaskW-1:0]  red;
    logic [phm_pkg::MaskW-1:0]  pk;
  } meter_word_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [phm_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [phm_pkg::CfgDataW-1:0] cfg_data_i;

  phm_in_if  in_ch ();
  phm_out_if out_ch ();

  peak_hold_bar_meter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // Samples waiting to be sent, and meter words predicted but not yet seen.
  sample_t     pending_samples[$];
  meter_word_t expected_words[$];

  // Register copies as the meter should hold them now.
  logic [phm_pkg::HoldW-1:0]  hold_ms_now;
  logic [phm_pkg::LevelW-1:0] green_now;

  // Meter state seen by the checker (advanced on accept) and by the stimulus
  // generator (advanced on queueing, so it can aim at the hold boundary).
  meter_state_t checker_state;
  meter_state_t gen_state;
  logic [phm_pkg::TimeW-1:0] gen_time;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned samples_taken;
  int unsigned words_checked;
  int unsigned mismatch_count;

  // Compute the meter update for one sample: the next state and the word
  // that the meter reports for it.
  function automatic void advance_meter(input meter_state_t cur, input sample_t s,
                                        input logic [phm_pkg::HoldW-1:0] hold,
                                        input logic [phm_pkg::LevelW-1:0] green,
                                        output meter_state_t nxt,
                                        output meter_word_t word);
    logic [phm_pkg::TimeW-1:0] elapsed;
    logic                      hold_over;
    logic [63:0]               lit;
    logic [63:0]               green_span;
    logic [63:0]               red;
    logic [6:0]                green_top;
    nxt = cur;
    // Elapsed time wraps modulo 2^32; a negative difference never passes.
    elapsed   = s.now_ms - cur.ptime;
    hold_over = !elapsed[phm_pkg::TimeW-1] && (elapsed > {16'b0, hold});
    if (s.level != cur.bar) begin
      if (s.level > cur.bar) begin
        // Rise: bar and peak jump, peak keeps the unclamped level.
        nxt.bar   = s.level;
        nxt.peak  = s.level;
        nxt.ptime = s.now_ms;
      end else begin
        // Fall: bar steps down by one, peak by one once the hold is over.
        if (hold_over) begin
          if (cur.peak != '0) nxt.peak = cur.peak - 1'b1;
          nxt.ptime = s.now_ms;
        end
        nxt.bar = cur.bar - 1'b1;
      end
      if (nxt.bar > MaxLevel) nxt.bar = phm_pkg::LevelW'(MaxLevel);
    end else if (cur.peak > cur.bar && hold_over) begin
      // Unchanged level: a peak above the bar decays by two, but the time
      // only advances when the peak was above one.
      nxt.peak = cur.peak - 1'b1;
      if (nxt.peak != '0) begin
        nxt.peak  = nxt.peak - 1'b1;
        nxt.ptime = s.now_ms;
      end
    end
    lit        = (64'd1 << nxt.bar) - 64'd1;
    green_top  = {1'b0, green} + 7'd1;
    green_span = (green_top == 7'd64) ? '1 : (64'd1 << green_top) - 64'd1;
    red        = lit & ~green_span;
    word.shown = nxt.bar;
    word.peak  = nxt.peak;
    word.lit   = lit[phm_pkg::MaskW-1:0];
    word.red   = red[phm_pkg::MaskW-1:0];
    word.pk    = (nxt.peak <= MaxLevel) ? (phm_pkg::MaskW'(1) << nxt.peak) : '0;
  endfunction

  // Pick a random sample. Most levels follow the bar (hold, fall, rise) so
  // the decay paths get exercised; timestamps mostly move forward, some land
  // right at the hold boundary, some step back or jump anywhere.
  function automatic sample_t pick_sample(input meter_state_t g,
                                          input logic [phm_pkg::TimeW-1:0] t_last,
                                          input logic [phm_pkg::HoldW-1:0] hold);
    sample_t     s;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) s.level = g.bar;
    else if (roll < 55) s.level = (g.bar == '0) ? '0 :
                                  phm_pkg::LevelW'($urandom_range(0, int'(g.bar) - 1));
    else if (roll < 75) s.level = phm_pkg::LevelW'($urandom_range(int'(g.bar) + 1, 63));
    else if (roll < 85) s.level = phm_pkg::LevelW'($urandom_range(MaxLevel + 1, 63));
    else s.level = phm_pkg::LevelW'($urandom_range(0, 63));
    roll = $urandom_range(0, 99);
    if (roll < 10) s.now_ms = $urandom;
    else if (roll < 25) s.now_ms = g.ptime + {16'b0, hold} + $urandom_range(0, 1);
    else if (roll < 35) s.now_ms = t_last - $urandom_range(0, 1000);
    else s.now_ms = t_last + $urandom_range(0, 2 * int'(hold) + 2);
    return s;
  endfunction

  // Queue one sample and advance the generator's view of the meter.
  task automatic queue_sample(input logic [phm_pkg::LevelW-1:0] level,
                              input logic [phm_pkg::TimeW-1:0] now);
    sample_t      s;
    meter_state_t nxt;
    meter_word_t  unused_word;
    s.level  = level;
    s.now_ms = now;
    advance_meter(gen_state, s, hold_ms_now, green_now, nxt, unused_word);
    gen_state = nxt;
    gen_time  = now;
    pending_samples.push_back(s);
  endtask

  task automatic queue_random(input int unsigned count);
    sample_t s;
    repeat (count) begin
      s = pick_sample(gen_state, gen_time, hold_ms_now);
      queue_sample(s.level, s.now_ms);
    end
  endtask

  // Hold until every queued sample is sent and every word has come back,
  // then let the two pipeline stages settle.
  task automatic drain;
    do @(posedge clk_i);
    while (pending_samples.size() != 0 || in_ch.valid || expected_words.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Write one register; only called while the meter is idle.
  task automatic write_reg(input phm_pkg::cfg_idx_e idx,
                           input logic [phm_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == phm_pkg::CFG_HOLD_MS) hold_ms_now = data[phm_pkg::HoldW-1:0];
    else green_now = data[phm_pkg::LevelW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Drive: take a new sample only once the current word is accepted (or none
  // is up), and idle between words at the current rate. Predict each accepted
  // sample right away.
  always @(posedge clk_i) begin : drive_samples
    sample_t      s;
    sample_t      taken;
    meter_state_t nxt;
    meter_word_t  word;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.level  = in_ch.level;
        taken.now_ms = in_ch.now_ms;
        advance_meter(checker_state, taken, hold_ms_now, green_now, nxt, word);
        checker_state = nxt;
        expected_words.push_back(word);
        samples_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          s = pending_samples.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.level  <= s.level;
          in_ch.now_ms <= s.now_ms;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, compare each accepted word with the oldest
  // prediction.
  always @(posedge clk_i) begin : check_words
    meter_word_t got;
    meter_word_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        got.shown = out_ch.shown_level;
        got.peak  = out_ch.peak_level;
        got.lit   = out_ch.lit_mask;
        got.red   = out_ch.red_mask;
        got.pk    = out_ch.peak_mask;
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: unexpected meter word shown=%0d peak=%0d at %0t",
                     got.shown, got.peak, $realtime);
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (got.shown !== want.shown || got.peak !== want.peak ||
              got.lit !== want.lit || got.red !== want.red || got.pk !== want.pk) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("ERROR: word %0d at %0t", words_checked, $realtime);
              $display("  expected shown=%0d peak=%0d lit=%h red=%h pk=%h",
                       want.shown, want.peak, want.lit, want.red, want.pk);
              $display("  actual   shown=%0d peak=%0d lit=%h red=%h pk=%h",
                       got.shown, got.peak, got.lit, got.red, got.pk);
            end
          end
        end
      end
    end
  end

  // Stimulus and phases.
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = phm_pkg::CFG_HOLD_MS;
    cfg_data_i    = '0;
    hold_ms_now   = phm_pkg::HoldMsReset;
    green_now     = phm_pkg::GreenLimitReset;
    checker_state = '0;
    gen_state     = '0;
    gen_time      = '0;
    tx_idle_pct   = 29;
    rx_idle_pct   = 46;
    samples_taken  = 0;
    words_checked  = 0;
    mismatch_count = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk under reset register values (hold 200, green 18).
    queue_sample(6'd0, 32'd0);             // level equals bar, nothing moves
    queue_sample(6'd2, 32'd10);            // rise
    queue_sample(6'd1, 32'd50);            // fall inside the hold
    queue_sample(6'd1, 32'd300);           // unchanged, peak decays by two
    queue_sample(6'd0, 32'd600);           // fall with peak already at zero
    queue_sample(6'd1, 32'd610);
    queue_sample(6'd0, 32'd620);           // peak left one above the bar
    queue_sample(6'd0, 32'd900);           // decay hits zero, time kept
    queue_sample(6'd0, 32'd811);
    queue_sample(6'd63, 32'd1000);         // rise past the top, bar clamps
    queue_sample(6'd42, 32'd1200);         // exactly the hold time: no decay
    queue_sample(6'd42, 32'd1201);         // one past the hold time
    queue_sample(6'd10, 32'd1300);
    queue_sample(6'd10, 32'd1402);         // fall after the hold
    queue_sample(6'd10, 32'h8000_057A);    // half-range jump reads negative
    queue_sample(6'd10, 32'd1401);         // time going backwards
    queue_sample(6'd43, 32'd2000);         // peak just above the top, no marker
    queue_sample(6'd42, 32'd2300);
    queue_sample(6'd42, 32'd2600);
    queue_sample(6'd18, 32'd2700);
    queue_sample(6'd19, 32'hFFFF_FFFF);
    queue_sample(6'd42, 32'd3000);         // marker on the top segment
    queue_sample(6'd0, 32'd3100);
    drain();

    // Zero hold, everything above segment zero red.
    write_reg(phm_pkg::CFG_HOLD_MS, 16'd0);
    write_reg(phm_pkg::CFG_GREEN_LIMIT, 16'd0);
    queue_random(200);
    drain();

    // Longest hold, no red at all; swap the stall rates.
    tx_idle_pct = 46;
    rx_idle_pct = 29;
    write_reg(phm_pkg::CFG_HOLD_MS, 16'hFFFF);
    write_reg(phm_pkg::CFG_GREEN_LIMIT, 16'd63);
    queue_random(200);
    drain();

    // Mid values at full rate, with one pause until every word is back.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(phm_pkg::CFG_HOLD_MS, 16'd150);
    write_reg(phm_pkg::CFG_GREEN_LIMIT, 16'd41);
    queue_random(100);
    drain();
    queue_random(100);
    drain();

    if (expected_words.size() != 0) mismatch_count++;
    $display("Checked %0d meter words from %0d level samples over three stall mixes",
             words_checked, samples_taken);
    $display("Hold times 200, 0, 65535, 150 ms; green limits 18, 0, 63, 41");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d bad meter words", mismatch_count);
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Run timed out");
    $display("Mismatches found");
    $finish;
  end

endmodule
